// ===== hw/rtl/ccd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and reset constants for the coincidence detector.
// No dependencies.
package ccd_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF  = 32;

    localparam int THR_W    = 16;
    localparam int WIN_W    = 10;
    localparam int BLANK_W  = 16;
    localparam int OUT_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [THR_W-1:0]   THR_RESET   = 16'hFFFF;
    localparam logic [WIN_W-1:0]   WIN_RESET   = 10'd45;
    localparam logic [BLANK_W-1:0] BLANK_RESET = 16'd600;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_THR_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK = 2'd3;

    typedef struct packed {
        logic [THR_W-1:0]   thr_a;
        logic [THR_W-1:0]   thr_b;
        logic [WIN_W-1:0]   window_len;
        logic [BLANK_W-1:0] blank_len;
    } t_cfg;

    typedef struct packed {
        logic             fire;
        logic [OUT_W-1:0] index;
    } t_result;

endpackage

// ===== hw/rtl/two_channel_coincidence_detector.sv =====
`timescale 1ns / 1ps
// Top level of the two-channel coincidence detector.
// Depends on ccd_pkg, ccd_cfg_regs, ccd_in_reg, ccd_core, ccd_out_reg.
//
// Usage:
//   Input channel: one envelope pair (i_env_a, i_env_b) per transfer, taken
//   when i_in_valid is high and o_in_stall is low. Each transfer is one sample
//   and advances the internal sample index by one.
//   Output channel: o_detect_index is offered with o_out_valid and taken when
//   i_out_stall is low. At most one result per input sample.
//   Config channel: write i_cfg_data to register i_cfg_index on
//   i_cfg_valid && o_cfg_ready (ready is always high). Indexes: 0 threshold A,
//   1 threshold B, 2 window length, 3 blanking length. Write only when idle.
// Timing:
//   A transferred sample is held in the input register and evaluated by the
//   core; its detection, if any, is then captured in the result register.
//   One sample per cycle sustained while no result waits under i_out_stall;
//   the core updates its state once per sample.
// Reset (synchronous, active low): index, window and blanking state cleared,
//   registers back to thresholds 65535, window 45, blanking 600.
// Stall: while a result waits under i_out_stall, the input register still
//   fills; once it holds an item too, o_in_stall rises until the result drains.
module two_channel_coincidence_detector #(
    parameter int SAMPLE_BITS = ccd_pkg::SAMPLE_BITS_DEF,
    parameter int INDEX_BITS  = ccd_pkg::INDEX_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [SAMPLE_BITS-1:0]            i_env_a,
    input  logic [SAMPLE_BITS-1:0]            i_env_b,
    // detection output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ccd_pkg::OUT_W-1:0]         o_detect_index,
    // config writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ccd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ccd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ccd_pkg::*;

    t_cfg                   cfg;
    t_result                res;
    logic                   advance;
    logic                   s1_valid;
    logic [SAMPLE_BITS-1:0] s1_env_a;
    logic [SAMPLE_BITS-1:0] s1_env_b;

    ccd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // stage 1: registered sample pair
    ccd_in_reg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_env_a   (i_env_a),
        .i_env_b   (i_env_b),
        .i_advance (advance),
        .o_valid   (s1_valid),
        .o_env_a   (s1_env_a),
        .o_env_b   (s1_env_b)
    );

    // threshold compare, window/blanking decision, state update
    ccd_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (s1_valid),
        .i_advance (advance),
        .i_env_a   (s1_env_a),
        .i_env_b   (s1_env_b),
        .o_res     (res)
    );

    // stage 2: result register toward the receiver
    ccd_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res     (res),
        .o_advance (advance),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_index   (o_detect_index)
    );

endmodule

// ===== hw/rtl/ccd_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file: thresholds, window length, blanking length.
// Depends on ccd_pkg.
module ccd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ccd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ccd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output ccd_pkg::t_cfg                     o_cfg
);
    import ccd_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_a      <= THR_RESET;
            r_cfg.thr_b      <= THR_RESET;
            r_cfg.window_len <= WIN_RESET;
            r_cfg.blank_len  <= BLANK_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_THR_A: r_cfg.thr_a      <= i_cfg_data;
                REG_THR_B: r_cfg.thr_b      <= i_cfg_data;
                REG_WIN:   r_cfg.window_len <= i_cfg_data[WIN_W-1:0];
                REG_BLANK: r_cfg.blank_len  <= i_cfg_data;
                default:   r_cfg            <= r_cfg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/ccd_in_reg.sv =====
`timescale 1ns / 1ps
// Input register stage holding one sample pair ahead of the detector core.
// Depends on nothing but the port widths handed down.
module ccd_in_reg #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [SAMPLE_BITS-1:0] i_env_a,
    input  logic [SAMPLE_BITS-1:0] i_env_b,
    input  logic                   i_advance,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_env_a,
    output logic [SAMPLE_BITS-1:0] o_env_b
);
    logic                   r_valid;
    logic [SAMPLE_BITS-1:0] r_env_a;
    logic [SAMPLE_BITS-1:0] r_env_b;

    // held item can only leave when the core advances
    assign o_stall = r_valid && !i_advance;
    assign o_valid = r_valid;
    assign o_env_a = r_env_a;
    assign o_env_b = r_env_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_env_a <= i_env_a;
            r_env_b <= i_env_b;
        end
    end

endmodule

// ===== hw/rtl/ccd_core.sv =====
`timescale 1ns / 1ps
// Detector core: sample index, window and blanking state, one-pass evaluation.
// Depends on ccd_pkg.
module ccd_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ccd_pkg::t_cfg          i_cfg,
    input  logic                   i_valid,
    input  logic                   i_advance,
    input  logic [SAMPLE_BITS-1:0] i_env_a,
    input  logic [SAMPLE_BITS-1:0] i_env_b,
    output ccd_pkg::t_result       o_res
);
    import ccd_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam logic [CMP_W-1:0] CMP_MASK = {CMP_W{1'b1}} >> (CMP_W - SAMPLE_BITS);

    logic [INDEX_BITS-1:0] r_sample_count;
    logic [INDEX_BITS-1:0] r_window_start;
    logic [BLANK_W-1:0]    r_blank_left;
    logic                  r_armed;
    logic                  r_seen_a;
    logic                  r_seen_b;

    logic [CMP_W-1:0]      env_a_x;
    logic [CMP_W-1:0]      env_b_x;
    logic [CMP_W-1:0]      thr_a_x;
    logic [CMP_W-1:0]      thr_b_x;
    logic                  cross_a;
    logic                  cross_b;
    logic                  step;
    logic                  blanked;
    logic                  expired;
    logic                  fire_early;
    logic                  fire_both;
    logic                  fire;
    logic [INDEX_BITS-1:0] win_dist;
    logic [BLANK_W-1:0]    blank_reload;

    assign env_a_x = CMP_W'(i_env_a);
    assign env_b_x = CMP_W'(i_env_b);
    assign thr_a_x = CMP_W'(i_cfg.thr_a) & CMP_MASK;
    assign thr_b_x = CMP_W'(i_cfg.thr_b) & CMP_MASK;
    assign cross_a = env_a_x > thr_a_x;
    assign cross_b = env_b_x > thr_b_x;

    assign step     = i_valid && i_advance;
    assign blanked  = (r_blank_left != '0);
    assign win_dist = r_sample_count - r_window_start;
    assign expired  = r_armed && (win_dist > INDEX_BITS'(i_cfg.window_len));

    // second channel crossing inside an open window
    assign fire_early = r_armed && ((!r_seen_a && cross_a) || (!r_seen_b && cross_b));
    // both seen after this sample's crossings are folded in
    assign fire_both  = (r_seen_a || cross_a) && (r_seen_b || cross_b);
    assign fire       = !blanked && !expired && (fire_early || fire_both);

    // zero blank length behaves as one
    assign blank_reload = (i_cfg.blank_len == '0) ? '0 : i_cfg.blank_len - BLANK_W'(1);

    assign o_res.fire  = i_valid && fire;
    assign o_res.index = OUT_W'(r_sample_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
            r_window_start <= '0;
            r_blank_left   <= '0;
            r_armed        <= 1'b0;
            r_seen_a       <= 1'b0;
            r_seen_b       <= 1'b0;
        end else if (step) begin
            r_sample_count <= r_sample_count + INDEX_BITS'(1);
            priority if (blanked) begin
                r_blank_left <= r_blank_left - BLANK_W'(1);
            end else if (expired) begin
                r_armed  <= 1'b0;
                r_seen_a <= 1'b0;
                r_seen_b <= 1'b0;
            end else if (fire) begin
                r_armed      <= 1'b0;
                r_seen_a     <= 1'b0;
                r_seen_b     <= 1'b0;
                r_blank_left <= blank_reload;
                if (!fire_early && (cross_a || cross_b)) begin
                    r_window_start <= r_sample_count;
                end
            end else begin
                if (cross_a || cross_b) begin
                    r_armed        <= 1'b1;
                    r_window_start <= r_sample_count;
                end
                if (cross_a) begin
                    r_seen_a <= 1'b1;
                end
                if (cross_b) begin
                    r_seen_b <= 1'b1;
                end
            end
        end
    end

    a_seen_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> (!r_seen_a && !r_seen_b))
        else $error("seen flag set while window not armed");

    a_never_both_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_seen_a && r_seen_b))
        else $error("both channels seen without a detection");

    a_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && fire) |=> (!r_armed && r_blank_left == $past(blank_reload)))
        else $error("detection did not clear window or load blanking");

    a_no_fire_blanked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blanked |-> !o_res.fire)
        else $error("detection during blanking");

endmodule

// ===== hw/rtl/ccd_out_reg.sv =====
`timescale 1ns / 1ps
// Result register: holds one detection index until the receiver takes it.
// Depends on ccd_pkg.
module ccd_out_reg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ccd_pkg::t_result          i_res,
    output logic                      o_advance,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [ccd_pkg::OUT_W-1:0] o_index
);
    import ccd_pkg::*;

    logic             r_valid;
    logic [OUT_W-1:0] r_index;

    // free when empty or being drained this cycle
    assign o_advance = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_index   = r_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res.fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res.fire) begin
            r_index <= i_res.index;
        end
    end

endmodule
